[sv/assert_macros.svh]
// Assertion macros used by the checker file of the stroke length detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsld assertion failed");

// Next-cycle implication, disabled during reset
`define TSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsld assertion failed");

`endif

[sv/tsld_pkg.sv]
// Shared types and constants of the touch stroke length detector.
package tsld_pkg;

  // Fixed field widths
  localparam int KIND_W       = 2;
  localparam int MIN_STEP_W   = 12;
  localparam int MIN_PATH_W   = 16;
  localparam int MIN_POINTS_W = 8;
  localparam int POINTS_W     = 8;
  localparam int PATH_OUT_W   = 24;
  localparam int OUT_W        = 40;

  // APB port geometry
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_MIN_STEP   = 2'd0;
  localparam logic [1:0] REG_MIN_PATH   = 2'd1;
  localparam logic [1:0] REG_MIN_POINTS = 2'd2;

  // Register reset values
  localparam logic [MIN_STEP_W-1:0]   MIN_STEP_RST   = 12'd10;
  localparam logic [MIN_PATH_W-1:0]   MIN_PATH_RST   = 16'd85;
  localparam logic [MIN_POINTS_W-1:0] MIN_POINTS_RST = 8'd3;

  typedef struct packed {
    logic [MIN_STEP_W-1:0]   min_step;
    logic [MIN_PATH_W-1:0]   min_path;
    logic [MIN_POINTS_W-1:0] min_points;
  } cfg_t;

endpackage

[sv/tsld_regs.sv]
// APB configuration registers of the touch stroke length detector.
module tsld_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsld_pkg::APB_AW-1:0] paddr,
  input  logic [tsld_pkg::APB_DW-1:0] pwdata,
  output logic [tsld_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tsld_pkg::cfg_t              cfg
);

  tsld_pkg::cfg_t cfg_r;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[tsld_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_step   <= tsld_pkg::MIN_STEP_RST;
      cfg_r.min_path   <= tsld_pkg::MIN_PATH_RST;
      cfg_r.min_points <= tsld_pkg::MIN_POINTS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tsld_pkg::REG_MIN_STEP:   cfg_r.min_step   <= pwdata[tsld_pkg::MIN_STEP_W-1:0];
        tsld_pkg::REG_MIN_PATH:   cfg_r.min_path   <= pwdata[tsld_pkg::MIN_PATH_W-1:0];
        tsld_pkg::REG_MIN_POINTS: cfg_r.min_points <= pwdata[tsld_pkg::MIN_POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      tsld_pkg::REG_MIN_STEP:   prdata = tsld_pkg::APB_DW'(cfg_r.min_step);
      tsld_pkg::REG_MIN_PATH:   prdata = tsld_pkg::APB_DW'(cfg_r.min_path);
      tsld_pkg::REG_MIN_POINTS: prdata = tsld_pkg::APB_DW'(cfg_r.min_points);
      default:                  prdata = '0;
    endcase
  end

endmodule

[sv/tsld_sermul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module tsld_sermul #(
  parameter int W = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int CNTW = $clog2(W + 1);

  logic [2*W-1:0] mcand_r;
  logic [W-1:0]   mplier_r;
  logic [2*W-1:0] acc_r;
  logic [2*W-1:0] acc_nxt;
  logic [CNTW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic           last_step;

  assign acc_nxt   = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign last_step = busy_r && (cnt_r == CNTW'(1));
  assign done      = done_r;
  assign product   = acc_r;

  // Sequence the W add steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift operands, accumulate partial products
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= (2*W)'(mcand);
      mplier_r <= mplier;
      acc_r    <= '0;
    end else if (busy_r) begin
      mcand_r  <= {mcand_r[2*W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[W-1:1]};
      acc_r    <= acc_nxt;
    end
  end

endmodule

[sv/tsld_isqrt.sv]
// Digit-serial restoring integer square root, two radicand bits per cycle.
module tsld_isqrt #(
  parameter int RW = 34
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);

  localparam int QW   = RW / 2;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rad_r;
  logic [QW:0]     rem_r;
  logic [QW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [QW+2:0]   rem_sh;
  logic [QW+2:0]   trial;
  logic [QW+2:0]   diff;
  logic            fits;
  logic [QW:0]     rem_nxt;
  logic            last_step;

  // One root digit: bring down two bits, try (root << 2) | 1
  assign rem_sh    = {rem_r, rad_r[RW-1 -: 2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign fits      = rem_sh >= trial;
  assign diff      = rem_sh - trial;
  assign rem_nxt   = fits ? diff[QW:0] : rem_sh[QW:0];
  assign last_step = busy_r && (cnt_r == CNTW'(1));
  assign done      = done_r;
  assign root      = root_r;

  // Sequence the QW digit steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift radicand, update remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[QW-2:0], fits};
    end
  end

endmodule

[sv/touch_stroke_length_detector.sv]
// Top level of the touch stroke length detector.
//
//   channel  | direction | transaction contents
//   ---------+-----------+---------------------------------------------------
//   in_      | slave     | tuser: kind; tdata: x_coord, y_coord
//   out_     | master    | tdata: swipe_found, path_length, points_kept
//   APB      | slave     | min_step @0x0, min_path @0x4, min_points @0x8
//
// Start, end and ignored events do not enter the datapath; a kept move passes through
// the bit-serial squarers (MW = max(COORD_BITS, 12)), the digit-serial square root
// (QW = MW + 5) and a handoff and accumulate step.
// A move that does not pass min_step skips the root and goes back to idle.
// Reset is synchronous, active low, and the block takes events at once after it.
// in_tready drops only while a move is in the datapath or a result waits untaken.
module touch_stroke_length_detector #(
  parameter int COORD_BITS  = 12,
  parameter int LENGTH_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tuser: kind[1:0]
  input  logic [tsld_pkg::KIND_W-1:0]       in_tuser,
  // in_tdata: x_coord[COORD_BITS-1:0], y_coord, zero padding to bytes
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: swipe_found[0], path_length[24:1], points_kept[32:25], zeros
  output logic [tsld_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsld_pkg::APB_AW-1:0]       paddr,
  input  logic [tsld_pkg::APB_DW-1:0]       pwdata,
  output logic [tsld_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int MW  = (COORD_BITS > tsld_pkg::MIN_STEP_W) ? COORD_BITS : tsld_pkg::MIN_STEP_W;
  localparam int D2W = 2 * MW + 1;
  localparam int RW  = 2 * MW + 10;
  localparam int QW  = RW / 2;
  localparam int SW  = ((LENGTH_BITS > QW) ? LENGTH_BITS : QW) + 1;
  localparam int CW  = (LENGTH_BITS > tsld_pkg::MIN_PATH_W + 4) ?
                       LENGTH_BITS : tsld_pkg::MIN_PATH_W + 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_SQRT = 3'b100
  } state_t;

  tsld_pkg::cfg_t cfg;

  state_t                        state_r, state_nxt;
  logic                          open_r;
  logic [COORD_BITS-1:0]         last_x_r, last_y_r;
  logic [COORD_BITS-1:0]         pend_x_r, pend_y_r;
  logic [tsld_pkg::POINTS_W-1:0] count_r;
  logic [LENGTH_BITS-1:0]        sum_r;
  logic                          out_valid_r;
  logic [tsld_pkg::OUT_W-1:0]    out_data_r;

  logic [tsld_pkg::KIND_W-1:0]   kind;
  logic [COORD_BITS-1:0]         x_in, y_in, dx, dy;
  logic                          in_acc;
  logic                          do_start, do_move, do_end;
  logic                          mul_start;
  logic                          done_x, done_y, done_s, mul_done;
  logic [2*MW-1:0]               prod_x, prod_y, prod_s;
  logic [D2W-1:0]                d2;
  logic                          step_ok;
  logic                          sqrt_start, sqrt_done;
  logic [QW-1:0]                 root;
  logic [SW-1:0]                 sum_ext;
  logic [LENGTH_BITS-1:0]        sum_nxt;
  logic [tsld_pkg::PATH_OUT_W-1:0] path_out;
  logic                          swipe;

  // Configuration registers
  tsld_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Decode the incoming transaction
  assign kind      = in_tuser;
  assign x_in      = in_tdata[COORD_BITS-1:0];
  assign y_in      = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign do_start  = in_acc && (kind == tsld_pkg::KIND_START);
  assign do_move   = in_acc && (kind == tsld_pkg::KIND_MOVE) && open_r;
  assign do_end    = in_acc && (kind == tsld_pkg::KIND_END) && open_r;

  assign dx        = (x_in >= last_x_r) ? (x_in - last_x_r) : (last_x_r - x_in);
  assign dy        = (y_in >= last_y_r) ? (y_in - last_y_r) : (last_y_r - y_in);
  assign mul_start = do_move;

  // Square dx, dy and min_step side by side
  tsld_sermul #(.W(MW)) u_sq_x (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .mcand (MW'(dx)), .mplier (MW'(dx)), .done (done_x), .product (prod_x)
  );

  tsld_sermul #(.W(MW)) u_sq_y (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .mcand (MW'(dy)), .mplier (MW'(dy)), .done (done_y), .product (prod_y)
  );

  tsld_sermul #(.W(MW)) u_sq_s (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .mcand (MW'(cfg.min_step)), .mplier (MW'(cfg.min_step)),
    .done (done_s), .product (prod_s)
  );

  assign mul_done   = done_x && done_y && done_s;
  assign d2         = D2W'(prod_x) + D2W'(prod_y);
  assign step_ok    = d2 > D2W'(prod_s);
  assign sqrt_start = (state_r == ST_MUL) && mul_done && step_ok;

  // Step length in Q4: sqrt(d2 * 256)
  tsld_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (RW'({d2, 8'h00})),
    .done     (sqrt_done),
    .root     (root)
  );

  // Saturating path accumulation
  assign sum_ext = SW'(sum_r) + SW'(root);
  assign sum_nxt = (sum_ext > SW'({LENGTH_BITS{1'b1}})) ?
                   {LENGTH_BITS{1'b1}} : sum_ext[LENGTH_BITS-1:0];

  // Clamp or zero-extend the path to the output field
  generate
    if (LENGTH_BITS > tsld_pkg::PATH_OUT_W) begin : g_clamp
      assign path_out = (|sum_r[LENGTH_BITS-1:tsld_pkg::PATH_OUT_W]) ?
                        {tsld_pkg::PATH_OUT_W{1'b1}} : sum_r[tsld_pkg::PATH_OUT_W-1:0];
    end else begin : g_extend
      assign path_out = tsld_pkg::PATH_OUT_W'(sum_r);
    end
  endgenerate

  assign swipe = (count_r >= cfg.min_points) &&
                 (CW'(sum_r) > CW'({cfg.min_path, 4'h0}));

  // Sequence a move through squaring and root
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (do_move) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = step_ok ? ST_SQRT : ST_IDLE;
      ST_SQRT: if (sqrt_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_start) begin
        open_r <= 1'b1;
      end else if (do_end) begin
        open_r <= 1'b0;
      end
      priority if (do_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stroke payload
  always_ff @(posedge clk) begin
    if (do_start) begin
      last_x_r <= x_in;
      last_y_r <= y_in;
      count_r  <= tsld_pkg::POINTS_W'(1);
      sum_r    <= '0;
    end else if ((state_r == ST_SQRT) && sqrt_done) begin
      last_x_r <= pend_x_r;
      last_y_r <= pend_y_r;
      sum_r    <= sum_nxt;
      if (count_r != {tsld_pkg::POINTS_W{1'b1}}) begin
        count_r <= count_r + tsld_pkg::POINTS_W'(1);
      end
    end
    if (do_move) begin
      pend_x_r <= x_in;
      pend_y_r <= y_in;
    end
  end

  // Load the result register on a closing end
  always_ff @(posedge clk) begin
    if (do_end) begin
      out_data_r <= tsld_pkg::OUT_W'({count_r, path_out, swipe});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/tsld_checker.sv]
// Port-level checker of the touch stroke length detector, bound to the top level.
`include "assert_macros.svh"

module tsld_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic [tsld_pkg::OUT_W-1:0]   out_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready
);

  // Hold a stalled result
  `TSLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Block input while a result waits
  `TSLD_ASSERT_IMPLY(a_in_blocked, clk, rst_n, out_tvalid && !out_tready, !in_tready)

  // Every reported stroke holds its start point
  `TSLD_ASSERT_IMPLY(a_points_nonzero, clk, rst_n, out_tvalid, out_tdata[32:25] != 8'h00)

  // A swipe always has some path
  `TSLD_ASSERT_IMPLY(a_swipe_path, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[24:1] != 24'h0)

endmodule

bind touch_stroke_length_detector tsld_checker u_tsld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
